### sv/disparity_to_depth_normalizer_assert.svh
// Assertion macros for the disparity-to-depth normalizer.
`ifndef DISPARITY_TO_DEPTH_NORMALIZER_ASSERT_SVH
`define DISPARITY_TO_DEPTH_NORMALIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define D2D_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define D2D_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### sv/d2d_pkg.sv
// ----------------------------------------------------------------------------
// d2d_pkg
// Shared types and constants of the disparity-to-depth normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package d2d_pkg;
  localparam int unsigned SpanFixMm = 1000;
  localparam int unsigned QuotW     = 28;   // fb*16 width
  localparam int unsigned IdxNumW   = 27;   // 510*span-ish numerator width

  typedef struct packed {
    logic signed [15:0] disparity;
    logic               opcode;
    logic               end_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  color_index;
    logic        pixel_valid;
    logic [15:0] depth_mm;
    logic [15:0] scale_near_mm;
    logic [16:0] scale_far_mm;
    logic        last_pixel;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat, start depth divide
    logic step_div;   // one quotient bit of a divider
    logic conv_done;  // latch depth result, do statistics, set up index divide
    logic load_out;   // write output register
  } d2d_cmd_t;

  typedef struct packed {
    logic div_last;   // current divide finishes this cycle
    logic mapping;    // held beat is a mapping beat
  } d2d_sts_t;
endpackage
`default_nettype wire

### sv/disparity_to_depth_normalizer.sv
// Each result beat comes from two bit-serial divides (depth, then index) with
// 28-bit quotients through one shared restoring divider.
// The block takes no new beat until the current one is done; statistics beats
// skip the index divide and return no result beat.
// Reset: asynchronous active low; registers return to 100000 / 7000,
// scale to 0..1000, running min/max cleared.
// ----------------------------------------------------------------------------
// disparity_to_depth_normalizer
// Converts disparity to depth and maps it to an inverted 8-bit index.
// ----------------------------------------------------------------------------
`default_nettype none
module disparity_to_depth_normalizer import d2d_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_beat_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_beat_t       out_data_o,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  localparam logic [2:0] AddrFb  = 3'd0;
  localparam logic [2:0] AddrMax = 3'd4;

  logic [23:0] fb_q;
  logic [15:0] maxd_q;
  d2d_cmd_t cmd;
  d2d_sts_t sts;

  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      AddrFb:  prdata = {8'd0, fb_q};
      AddrMax: prdata = {16'd0, maxd_q};
      default: prdata = '0;
    endcase
  end

  // register writes land on the APB access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q   <= 24'd100000;
      maxd_q <= 16'd7000;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrFb)  fb_q   <= pwdata[23:0];
      if (paddr == AddrMax) maxd_q <= pwdata[15:0];
    end
  end

  d2d_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  d2d_datapath #(.DEPTH_BITS(DEPTH_BITS)) u_dp (
    .clk_i, .rst_ni, .focal_baseline_i(fb_q), .max_depth_mm_i(maxd_q),
    .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );
endmodule
`default_nettype wire

### sv/d2d_datapath.sv
// ----------------------------------------------------------------------------
// d2d_datapath
// Restoring divider shared by depth and index divides, statistics, output.
// ----------------------------------------------------------------------------
`default_nettype none
module d2d_datapath import d2d_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [23:0] focal_baseline_i,
  input  wire logic [15:0] max_depth_mm_i,
  input  wire in_beat_t    in_i,
  input  wire d2d_cmd_t    cmd_i,
  output d2d_sts_t         sts_o,
  output out_beat_t        out_o
);
  localparam logic [DEPTH_BITS-1:0] AllOnes = {DEPTH_BITS{1'b1}};
  localparam int unsigned CntW = $clog2(QuotW + 1);

  in_beat_t             beat_q;
  logic [QuotW-1:0]     num_q, num_d;       // dividend shifting into quotient
  logic [QuotW-1:0]     rem_q, rem_d;
  logic [QuotW-1:0]     den_q;
  logic [CntW-1:0]      cnt_q;
  logic [15:0]          depth_q;
  logic                 valid_q;
  logic [DEPTH_BITS-1:0] rmin_q, rmax_q;
  logic                 seen_q;
  logic [15:0]          fmin_q;
  logic [16:0]          fmax_q;
  logic                 idx_zero_q;
  out_beat_t            out_q;

  // restoring division step
  logic [QuotW:0] trial;
  logic [QuotW:0] rsh;
  assign rsh   = {rem_q, num_q[QuotW-1]};
  assign trial = rsh - {1'b0, den_q};
  assign rem_d = trial[QuotW] ? rsh[QuotW-1:0] : trial[QuotW-1:0];
  assign num_d = {num_q[QuotW-2:0], ~trial[QuotW]};

  // depth check on quotient
  logic [DEPTH_BITS-1:0] limit;
  logic [QuotW-1:0] z;
  logic zvalid;
  assign limit = ({{(QuotW-16){1'b0}}, max_depth_mm_i} > QuotW'(AllOnes)) ?
                 AllOnes : DEPTH_BITS'(max_depth_mm_i);
  assign z = num_q;
  assign zvalid = (beat_q.disparity > 0) && (z != '0) &&
                  (z <= QuotW'(limit));

  // freeze values
  logic [16:0] nmin, nmax, fmin_w, fmax_w;
  logic [DEPTH_BITS-1:0] umin, umax;
  logic        s;
  always_comb begin
    s    = seen_q || zvalid;
    umin = (zvalid && DEPTH_BITS'(z) < rmin_q) ? DEPTH_BITS'(z) : rmin_q;
    umax = (zvalid && DEPTH_BITS'(z) > rmax_q) ? DEPTH_BITS'(z) : rmax_q;
    nmin = s ? 17'(umin) : '0;
    nmax = s ? 17'(umax) : '0;
    fmin_w = nmin;
    fmax_w = (nmax <= nmin) ? nmin + 17'(SpanFixMm) : nmax;
  end

  logic [16:0] span, diff;
  assign span = fmax_q - {1'b0, fmin_q};
  assign diff = fmax_q - 17'(z);

  assign sts_o.div_last = (cnt_q == CntW'(QuotW - 1));
  assign sts_o.mapping  = beat_q.opcode;
  assign out_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q <= AllOnes;
      rmax_q <= '0;
      seen_q <= 1'b0;
      fmin_q <= '0;
      fmax_q <= 17'(SpanFixMm);
      cnt_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q   <= '0;
      end else if (cmd_i.step_div) begin
        cnt_q <= sts_o.div_last ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.conv_done) begin
        if (!beat_q.opcode) begin
          if (beat_q.end_of_frame) begin
            fmin_q <= fmin_w[15:0];
            fmax_q <= fmax_w;
            rmin_q <= AllOnes;
            rmax_q <= '0;
            seen_q <= 1'b0;
          end else begin
            rmin_q <= umin;
            rmax_q <= umax;
            seen_q <= s;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      beat_q <= in_i;
      num_q  <= (in_i.disparity > 0) ? {focal_baseline_i, 4'b0} : '0;
      den_q  <= QuotW'(in_i.disparity[15:0]);
      rem_q  <= '0;
    end else if (cmd_i.step_div) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
    if (cmd_i.conv_done) begin
      depth_q    <= zvalid ? z[15:0] : '0;
      valid_q    <= zvalid;
      idx_zero_q <= (z >= QuotW'(fmax_q));
      // index = (510*diff + span) / (2*span)
      num_q <= QuotW'(IdxNumW'(diff) * IdxNumW'(510) + IdxNumW'(span));
      den_q <= QuotW'({span, 1'b0});
      rem_q <= '0;
    end
    if (cmd_i.load_out) begin
      out_q.color_index   <= (!valid_q || idx_zero_q) ? 8'd0 :
                             (num_q > QuotW'(255)) ? 8'd255 : num_q[7:0];
      out_q.pixel_valid   <= valid_q;
      out_q.depth_mm      <= depth_q;
      out_q.scale_near_mm <= fmin_q;
      out_q.scale_far_mm  <= fmax_q;
      out_q.last_pixel    <= beat_q.end_of_frame;
    end
  end

  `include "disparity_to_depth_normalizer_assert.svh"
  `D2D_ASSERT_IMP(a_span_pos, clk_i, rst_ni, 1'b1, fmax_q > {1'b0, fmin_q})
  `D2D_ASSERT_NXT(a_load_clr, clk_i, rst_ni, cmd_i.load, cnt_q == '0)
  `D2D_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1,
    $onehot0({cmd_i.load, cmd_i.step_div, cmd_i.conv_done, cmd_i.load_out}))
endmodule
`default_nettype wire

### sv/d2d_ctrl.sv
// ----------------------------------------------------------------------------
// d2d_ctrl
// Sequencer: accept, depth divide, stats/setup, then index divide and output for mapping beats.
// ----------------------------------------------------------------------------
`default_nettype none
module d2d_ctrl import d2d_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire d2d_sts_t sts_i,
  output d2d_cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_DIV1, S_POST, S_DIV2, S_OUT
  } state_e;
  state_e state_q;
  logic   ovalid_q;

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == S_IDLE);
    cmd_o.load = in_ready_o && in_valid_i;
    case (state_q)
      S_DIV1:  cmd_o.step_div = 1'b1;
      S_DIV2:  cmd_o.step_div = 1'b1;
      S_POST:  cmd_o.conv_done = 1'b1;
      S_OUT:   cmd_o.load_out = !ovalid_q || out_ready_i;
      default: ;
    endcase
  end
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      // a new result beat replaces the one taken at this edge
      if (cmd_o.load_out) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (cmd_o.load) state_q <= S_DIV1;
        S_DIV1: if (sts_i.div_last) state_q <= S_POST;
        S_POST: state_q <= sts_i.mapping ? S_DIV2 : S_IDLE;
        S_DIV2: if (sts_i.div_last) state_q <= S_OUT;
        S_OUT: begin
          if (cmd_o.load_out) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `include "disparity_to_depth_normalizer_assert.svh"
  `D2D_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `D2D_ASSERT_NXT(a_out_set, clk_i, rst_ni, cmd_o.load_out, out_valid_o)
  `D2D_ASSERT_IMP(a_rdy_idle, clk_i, rst_ni, in_ready_o, !cmd_o.step_div)
endmodule
`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives disparity frames through the normalizer in statistics and mapping
// passes. It predicts depth, validity, frozen scale and color index per mapping beat,
// and checks every output beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench import d2d_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegFocalBaseline = 3'd0;
  localparam logic [2:0] RegMaxDepth      = 3'd4;
  localparam bit         OpStats          = 1'b0;
  localparam bit         OpMapping        = 1'b1;
  localparam int         DepthAllOnes     = 65535;
  localparam int         DrainCycles      = 70;   // longer than one beat's pass through the block

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  disparity_to_depth_normalizer dut (.*);

  always #10 clk_i = ~clk_i;

  // Mirror of the block's registers and frame statistics.
  longint unsigned focal_baseline_q, max_depth_q;
  longint unsigned run_min_q, run_max_q, frozen_min_q, frozen_max_q;
  bit              any_valid_q;

  out_beat_t pending_pixels[$];
  int        errors = 0;
  int        beats_sent = 0;
  int        hold_left = 0;   // long receiver hold-off, set by a test
  int        frame_len;
  logic signed [15:0] frame_disp[$];

  // Depth of one disparity; 0 when invalid.
  function automatic longint unsigned depth_of(logic signed [15:0] disp);
    longint unsigned d, z, limit;
    d = longint'(disp) & 64'hFFFF;
    limit = (max_depth_q > DepthAllOnes) ? DepthAllOnes : max_depth_q;
    if (disp[15] || d == 0) return 0;
    z = (focal_baseline_q * 16) / d;
    if (z > limit) return 0;
    return z;
  endfunction

  // Updates statistics or queues the expected pixel for one accepted beat.
  function automatic void model_beat(in_beat_t b);
    longint unsigned z, span, q;
    out_beat_t px;
    z = depth_of(b.disparity);
    if (b.opcode == OpStats) begin
      if (z != 0) begin
        if (z < run_min_q) run_min_q = z;
        if (z > run_max_q) run_max_q = z;
        any_valid_q = 1'b1;
      end
      if (b.end_of_frame) begin
        frozen_min_q = any_valid_q ? run_min_q : 0;
        frozen_max_q = any_valid_q ? run_max_q : 0;
        if (frozen_max_q <= frozen_min_q) frozen_max_q = frozen_min_q + SpanFixMm;
        run_min_q = DepthAllOnes;
        run_max_q = 0;
        any_valid_q = 1'b0;
      end
      return;
    end
    span = frozen_max_q - frozen_min_q;
    q = 0;
    if (z != 0 && z < frozen_max_q) begin
      q = (510 * (frozen_max_q - z) + span) / (2 * span);
      if (q > 255) q = 255;
    end
    px.color_index   = q[7:0];
    px.pixel_valid   = (z != 0);
    px.depth_mm      = z[15:0];
    px.scale_near_mm = frozen_min_q[15:0];
    px.scale_far_mm  = frozen_max_q[16:0];
    px.last_pixel    = b.end_of_frame;
    pending_pixels.push_back(px);
  endfunction

  function automatic int draw_gap();
    // Roughly half the beats go back to back.
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 8);
  endfunction

  // Sends one beat; valid stays high from beat to beat when there is no gap.
  task automatic send_pixel(logic signed [15:0] disp, bit op, bit eof);
    int gap;
    in_beat_t b;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    b.disparity = disp;
    b.opcode = op;
    b.end_of_frame = eof;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    model_beat(b);
    beats_sent++;
  endtask

  // Waits until every expected pixel is back and the pipeline is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, longint unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == RegFocalBaseline) focal_baseline_q = value & 64'hFFFFFF;
    else                          max_depth_q      = value & 64'hFFFF;
  endtask

  task automatic set_config(longint unsigned fb, longint unsigned maxd);
    drain();
    reg_write(RegFocalBaseline, fb);
    reg_write(RegMaxDepth, maxd);
  endtask

  // Sends a frame as a mapping pass, preceded by a statistics pass when with_stats is set.
  task automatic run_frame(bit with_stats);
    if (with_stats)
      foreach (frame_disp[i]) send_pixel(frame_disp[i], OpStats, i == frame_disp.size() - 1);
    foreach (frame_disp[i]) send_pixel(frame_disp[i], OpMapping, i == frame_disp.size() - 1);
  endtask

  function automatic logic signed [15:0] draw_disparity();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 16'($urandom_range(200, 8000));
    if (pick < 8) return 16'($urandom_range(0, 65535));
    if (pick < 9) return 16'($urandom_range(1, 300));
    case ($urandom_range(0, 3))
      0: return 16'sd0;
      1: return -16'sd1;
      2: return 16'sh8000;
      default: return 16'sh7FFF;
    endcase
  endfunction

  // ---- tests ---------------------------------------------------------------

  // Mapping with no statistics pass yet uses the reset scale 0..1000.
  task automatic test_reset_scale();
    frame_disp = '{16'sd1600, 16'sd3200, 16'sd1000, 16'sd16000};
    run_frame(1'b0);
  endtask

  // Field extremes and invalid disparities.
  task automatic test_edges();
    frame_disp = '{16'sd0, -16'sd1, 16'sh8000, 16'sh7FFF, 16'sd1, 16'sd228, 16'sd229, 16'sd400};
    run_frame(1'b1);
  endtask

  // No valid pixel, then a single valid depth: both take the span fix.
  task automatic test_span_fix();
    frame_disp = '{16'sd0, -16'sd5};
    run_frame(1'b1);
    frame_disp = '{16'sd800, 16'sd800};
    run_frame(1'b1);
  endtask

  // Map pixels against another frame's scale: clamp at both ends.
  task automatic test_outside_scale();
    frame_disp = '{16'sd500, 16'sd1000};
    run_frame(1'b1);
    frame_disp = '{16'sd4000, 16'sd250, 16'sd700};
    run_frame(1'b0);
  endtask

  task automatic test_config_extremes();
    set_config(1, 65535);
    frame_disp = '{16'sd1, 16'sd2, 16'sd16, 16'sd17};
    run_frame(1'b1);
    set_config(24'hFFFFFF, 1);
    frame_disp = '{16'sh7FFF, 16'sd100};
    run_frame(1'b1);
    set_config(24'hFFFFFF, 65535);
    frame_disp = '{16'sd4096, 16'sd4095, 16'sh7FFF, 16'sd8000};
    run_frame(1'b1);
  endtask

  // Receiver stalls for a long stretch while beats keep coming.
  task automatic test_backpressure();
    set_config(100000, 7000);
    hold_left = 2000;
    frame_disp.delete();
    repeat (12) frame_disp.push_back(draw_disparity());
    run_frame(1'b1);
  endtask

  task automatic test_random();
    int kind, n, target;
    target = beats_sent + 1700;
    while (beats_sent < target) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: set_config($urandom_range(1, 24'hFFFFFF), $urandom_range(1, 65535));
          1: set_config($urandom_range(20000, 400000), $urandom_range(1000, 20000));
          2: set_config(100000, 7000);
          default: set_config($urandom_range(1, 24'hFFFFFF), 65535);
        endcase
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      frame_disp.delete();
      repeat (n) frame_disp.push_back(draw_disparity());
      kind = $urandom_range(0, 9);
      if (kind < 8) run_frame(1'b1);
      else if (kind == 8) run_frame(1'b0);
      else begin
        // broken pass: statistics beats with no end of frame, then a mapping pass
        foreach (frame_disp[i]) send_pixel(frame_disp[i], OpStats, 1'b0);
        run_frame(1'b0);
      end
    end
  endtask

  // ---- receiver and checker ------------------------------------------------

  initial begin : receiver
    int gap_left;
    gap_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready_i <= 1'b0;
      end else if (out_ready_i && out_valid_o) begin
        gap_left = draw_gap();
        out_ready_i <= (gap_left == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected output beat %h", out_data_o);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data_o.color_index !== want.color_index) begin
          $error("color_index exp %0d got %0d", want.color_index, out_data_o.color_index);
          errors++;
        end
        if (out_data_o.pixel_valid !== want.pixel_valid) begin
          $error("pixel_valid exp %0d got %0d", want.pixel_valid, out_data_o.pixel_valid);
          errors++;
        end
        if (out_data_o.depth_mm !== want.depth_mm) begin
          $error("depth_mm exp %0d got %0d", want.depth_mm, out_data_o.depth_mm);
          errors++;
        end
        if (out_data_o.scale_near_mm !== want.scale_near_mm) begin
          $error("scale_near_mm exp %0d got %0d", want.scale_near_mm,
                 out_data_o.scale_near_mm);
          errors++;
        end
        if (out_data_o.scale_far_mm !== want.scale_far_mm) begin
          $error("scale_far_mm exp %0d got %0d", want.scale_far_mm, out_data_o.scale_far_mm);
          errors++;
        end
        if (out_data_o.last_pixel !== want.last_pixel) begin
          $error("last_pixel exp %0d got %0d", want.last_pixel, out_data_o.last_pixel);
          errors++;
        end
      end
    end
  end

  // ---- sequence ------------------------------------------------------------

  initial begin
    focal_baseline_q = 100000;
    max_depth_q      = 7000;
    run_min_q        = DepthAllOnes;
    run_max_q        = 0;
    any_valid_q      = 1'b0;
    frozen_min_q     = 0;
    frozen_max_q     = SpanFixMm;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_scale();
    test_edges();
    test_span_fix();
    test_outside_scale();
    test_config_extremes();
    test_backpressure();
    set_config(100000, 7000);
    test_random();
    drain();
    if (errors == 0) $display("disparity_to_depth_normalizer: match");
    else $display("disparity_to_depth_normalizer: mismatch");
    $finish;
  end

  initial begin
    #30ms;
    $display("disparity_to_depth_normalizer: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
